// ===== sv/dilp_pkg.sv =====
// ----------------------------------------------------------------------------
// dilp_pkg
// types and constants shared by the dictionary index line parser
// ----------------------------------------------------------------------------
package dilp_pkg;

    typedef enum logic [1:0] {
        KIND_KEY     = 2'd0,
        KIND_RECORD  = 2'd1,
        KIND_DISCARD = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        FLD_KEY    = 2'd0,
        FLD_OFFSET = 2'd1,
        FLD_LENGTH = 2'd2,
        FLD_REST   = 2'd3
    } t_field;

    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_LEAD      = 8'hD0;
    localparam logic [7:0] CH_LEAD_ALT  = 8'hD1;
    localparam logic [7:0] CASE_DELTA   = 8'h20;
    localparam logic [7:0] CYR_LO_FIRST = 8'h90;
    localparam logic [7:0] CYR_LO_LAST  = 8'h9F;
    localparam logic [7:0] CYR_HI_FIRST = 8'hA0;
    localparam logic [7:0] CYR_HI_LAST  = 8'hAF;

    localparam logic [5:0] B64_LOWER_BASE = 6'd26;
    localparam logic [5:0] B64_DIGIT_BASE = 6'd52;
    localparam logic [5:0] B64_PLUS       = 6'd62;
    localparam logic [5:0] B64_SLASH      = 6'd63;

    localparam int OBUF_DEPTH = 4;
    localparam int OBUF_AW    = $clog2(OBUF_DEPTH);

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_input;
    } t_in;

    typedef struct packed {
        t_kind       result_kind;
        logic [7:0]  key_byte;
        logic [31:0] record_offset;
        logic [31:0] record_length;
        logic        value_overflow;
        logic        last_result;
    } t_out;

    typedef struct packed {
        logic [1:0] count;
        t_out       first;
        t_out       second;
    } t_push;

    // valid flag on top, digit value below
    function automatic logic [6:0] b64_digit(input logic [7:0] b);
        logic [6:0] r;
        r = 7'd0;
        if (b inside {["A":"Z"]}) begin
            r = {1'b1, 6'(b - 8'h41)};
        end else if (b inside {["a":"z"]}) begin
            r = {1'b1, 6'(b - 8'h61) + B64_LOWER_BASE};
        end else if (b inside {["0":"9"]}) begin
            r = {1'b1, 6'(b - 8'h30) + B64_DIGIT_BASE};
        end else if (b == 8'h2B) begin
            r = {1'b1, B64_PLUS};
        end else if (b == 8'h2F) begin
            r = {1'b1, B64_SLASH};
        end
        return r;
    endfunction

    function automatic t_out key_result(input logic [7:0] b);
        t_out r;
        r = '0;
        r.result_kind = KIND_KEY;
        r.key_byte    = b;
        return r;
    endfunction

endpackage

// ===== sv/dilp_chan_if.sv =====
// ----------------------------------------------------------------------------
// dilp_chan_if
// valid/ready channel carrying one payload per transfer
// ----------------------------------------------------------------------------
interface dilp_chan_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/dict_index_line_parser_core.sv =====
// latency: a result can be taken in the cycle after its byte is transferred in
// throughput: one byte per cycle while the four-entry result queue has room for two;
// a byte that gives two results writes both into the queue together; they leave it one per transfer
// reset: synchronous, active low; clears line state and empties the queue
// ----------------------------------------------------------------------------
// dict_index_line_parser_core
// parses index lines into folded key bytes, discard results and decoded offset/length records
// ----------------------------------------------------------------------------
module dict_index_line_parser_core #(
    parameter int VALUE_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dilp_chan_if.sink   i_in,
    dilp_chan_if.source o_out
);

    logic            space;
    logic            accept;
    dilp_pkg::t_push push;

    assign i_in.ready = space;
    assign accept     = i_in.valid & space;

    dilp_parse #(
        .VALUE_BITS (VALUE_BITS)
    ) u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_in.data),
        .o_push   (push)
    );

    dilp_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_space (space),
        .o_out   (o_out)
    );

endmodule

// ===== sv/dilp_parse.sv =====
// ----------------------------------------------------------------------------
// dilp_parse
// line state, key case folding and base64 field decoding for one byte
// ----------------------------------------------------------------------------
module dilp_parse #(
    parameter int VALUE_BITS = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  dilp_pkg::t_in   i_item,
    output dilp_pkg::t_push o_push
);

    dilp_pkg::t_field        r_field, n_field;
    logic                    r_lead, n_lead;
    logic                    r_nonempty, n_nonempty;
    logic [VALUE_BITS-1:0]   r_off, n_off;
    logic                    r_off_stop, n_off_stop;
    logic [VALUE_BITS-1:0]   r_len, n_len;
    logic                    r_len_stop, n_len_stop;
    logic                    r_ovf, n_ovf;

    logic [7:0]              b;
    logic [6:0]              dig;
    logic                    close_req;
    logic [63:0]             ext_off;
    logic [63:0]             ext_len;
    dilp_pkg::t_out          closing;
    dilp_pkg::t_out          res [2];
    logic [1:0]              cnt;

    assign b       = i_item.data_byte;
    assign dig     = dilp_pkg::b64_digit(b);
    assign ext_off = 64'(r_off);
    assign ext_len = 64'(r_len);

    always_comb begin
        closing = '0;
        if (r_field == dilp_pkg::FLD_LENGTH || r_field == dilp_pkg::FLD_REST) begin
            closing.result_kind    = dilp_pkg::KIND_RECORD;
            closing.record_offset  = ext_off[31:0];
            closing.record_length  = ext_len[31:0];
            closing.value_overflow = r_ovf | (|ext_off[63:32]) | (|ext_len[63:32]);
        end else begin
            closing.result_kind = dilp_pkg::KIND_DISCARD;
        end
    end

    always_comb begin
        n_field    = r_field;
        n_lead     = r_lead;
        n_nonempty = r_nonempty;
        n_off      = r_off;
        n_off_stop = r_off_stop;
        n_len      = r_len;
        n_len_stop = r_len_stop;
        n_ovf      = r_ovf;
        res[0]     = '0;
        res[1]     = '0;
        cnt        = 2'd0;
        close_req  = 1'b0;
        if (i_accept) begin
            if (i_item.end_of_input) begin
                close_req = r_nonempty | r_lead;
            end else if (b == dilp_pkg::CH_LF) begin
                close_req = 1'b1;
            end else begin
                n_nonempty = 1'b1;
                case (r_field)
                    dilp_pkg::FLD_KEY: begin
                        if (b == dilp_pkg::CH_TAB) begin
                            if (r_lead) begin
                                res[0] = dilp_pkg::key_result(dilp_pkg::CH_LEAD);
                                cnt    = 2'd1;
                            end
                            n_lead  = 1'b0;
                            n_field = dilp_pkg::FLD_OFFSET;
                        end else if (r_lead) begin
                            n_lead = 1'b0;
                            cnt    = 2'd2;
                            if (b inside {[dilp_pkg::CYR_LO_FIRST:dilp_pkg::CYR_LO_LAST]}) begin
                                res[0] = dilp_pkg::key_result(dilp_pkg::CH_LEAD);
                                res[1] = dilp_pkg::key_result(b + dilp_pkg::CASE_DELTA);
                            end else if (b inside
                                    {[dilp_pkg::CYR_HI_FIRST:dilp_pkg::CYR_HI_LAST]}) begin
                                res[0] = dilp_pkg::key_result(dilp_pkg::CH_LEAD_ALT);
                                res[1] = dilp_pkg::key_result(b - dilp_pkg::CASE_DELTA);
                            end else begin
                                res[0] = dilp_pkg::key_result(dilp_pkg::CH_LEAD);
                                res[1] = dilp_pkg::key_result(b);
                            end
                        end else if (b == dilp_pkg::CH_LEAD) begin
                            n_lead = 1'b1;
                        end else if (b inside {["A":"Z"]}) begin
                            res[0] = dilp_pkg::key_result(b + dilp_pkg::CASE_DELTA);
                            cnt    = 2'd1;
                        end else begin
                            res[0] = dilp_pkg::key_result(b);
                            cnt    = 2'd1;
                        end
                    end
                    dilp_pkg::FLD_OFFSET: begin
                        if (b == dilp_pkg::CH_TAB) begin
                            n_field = dilp_pkg::FLD_LENGTH;
                        end else if (!r_off_stop) begin
                            if (!dig[6]) begin
                                n_off_stop = 1'b1;
                            end else begin
                                if (|r_off[VALUE_BITS-1 -: 6]) begin
                                    n_ovf = 1'b1;
                                end
                                n_off = {r_off[VALUE_BITS-7:0], dig[5:0]};
                            end
                        end
                    end
                    dilp_pkg::FLD_LENGTH: begin
                        if (b == dilp_pkg::CH_TAB) begin
                            n_field = dilp_pkg::FLD_REST;
                        end else if (!r_len_stop) begin
                            if (!dig[6]) begin
                                n_len_stop = 1'b1;
                            end else begin
                                if (|r_len[VALUE_BITS-1 -: 6]) begin
                                    n_ovf = 1'b1;
                                end
                                n_len = {r_len[VALUE_BITS-7:0], dig[5:0]};
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (close_req) begin
                if (r_lead) begin
                    res[0] = dilp_pkg::key_result(dilp_pkg::CH_LEAD);
                    res[1] = closing;
                    cnt    = 2'd2;
                end else begin
                    res[0] = closing;
                    cnt    = 2'd1;
                end
                n_field    = dilp_pkg::FLD_KEY;
                n_lead     = 1'b0;
                n_nonempty = 1'b0;
                n_off      = '0;
                n_off_stop = 1'b0;
                n_len      = '0;
                n_len_stop = 1'b0;
                n_ovf      = 1'b0;
            end
            if (cnt != 2'd0) begin
                res[1'(cnt - 2'd1)].last_result = 1'b1;
            end
        end
    end

    assign o_push.count  = cnt;
    assign o_push.first  = res[0];
    assign o_push.second = res[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field    <= dilp_pkg::FLD_KEY;
            r_lead     <= 1'b0;
            r_nonempty <= 1'b0;
            r_off      <= '0;
            r_off_stop <= 1'b0;
            r_len      <= '0;
            r_len_stop <= 1'b0;
            r_ovf      <= 1'b0;
        end else begin
            r_field    <= n_field;
            r_lead     <= n_lead;
            r_nonempty <= n_nonempty;
            r_off      <= n_off;
            r_off_stop <= n_off_stop;
            r_len      <= n_len;
            r_len_stop <= n_len_stop;
            r_ovf      <= n_ovf;
        end
    end

endmodule

// ===== sv/dilp_obuf.sv =====
// ----------------------------------------------------------------------------
// dilp_obuf
// result queue taking up to two results per cycle, giving one per transfer
// ----------------------------------------------------------------------------
module dilp_obuf (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  dilp_pkg::t_push i_push,
    output logic            o_space,
    dilp_chan_if.source     o_out
);

    localparam int CW = dilp_pkg::OBUF_AW + 1;

    dilp_pkg::t_out                r_mem [dilp_pkg::OBUF_DEPTH];
    logic [dilp_pkg::OBUF_AW-1:0]  r_wp, n_wp;
    logic [dilp_pkg::OBUF_AW-1:0]  r_rp, n_rp;
    logic [CW-1:0]                 r_count, n_count;
    logic                          pop;
    logic [dilp_pkg::OBUF_AW-1:0]  wp_next;

    assign o_space     = (r_count <= CW'(dilp_pkg::OBUF_DEPTH - 2));
    assign o_out.valid = (r_count != '0);
    assign o_out.data  = r_mem[r_rp];
    assign pop         = o_out.valid & o_out.ready;
    assign wp_next     = r_wp + dilp_pkg::OBUF_AW'(1);

    always_comb begin
        n_wp    = r_wp + dilp_pkg::OBUF_AW'(i_push.count);
        n_rp    = r_rp + dilp_pkg::OBUF_AW'(pop);
        n_count = r_count + CW'(i_push.count) - CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wp] <= i_push.first;
        end
        if (i_push.count == 2'd2) begin
            r_mem[wp_next] <= i_push.second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

endmodule
